// ===== rtl/core/slnu_pkg.sv =====
`default_nettype none
package slnu_pkg;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONPOS = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCALE_MODE  = 2'd0;
  localparam logic [1:0] REG_LOWER_BOUND = 2'd1;
  localparam logic [1:0] REG_UPPER_BOUND = 2'd2;

  // Fraction bits of the internal log2 value.
  localparam int LOG_FB = 28;
  // 20*log10(2) with LOG_FB fraction bits.
  localparam logic [30:0] DB_FACTOR = 31'd1616142483;
  // Quotient bits of the Q1.16 level.
  localparam int LEVEL_W = 17;

  // Side information that travels with every word through the pipeline.
  typedef struct packed {
    logic [1:0] status;
    logic       wend;
  } slnu_tag_t;

  // log2(1 + i/2^ltb) with LOG_FB fraction bits, by truncating
  // square-and-compare on a Q1.30 mantissa. Evaluated at elaboration only.
  function automatic logic [28:0] log_rom(input int unsigned i, input int unsigned ltb);
    longint unsigned y;
    longint unsigned r;
    r = 0;
    if (i >= (32'd1 << ltb)) begin
      return 29'(64'd1 << LOG_FB);
    end
    y = (64'd1 << 30) + (64'(i) << (30 - ltb));
    for (int k = 0; k < LOG_FB; k++) begin
      y = (y * y) >> 30;
      r = r << 1;
      if (y >= (64'd2 << 30)) begin
        r = r | 64'd1;
        y = y >> 1;
      end
    end
    return r[28:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/slnu_log_conv.sv =====
`default_nettype none
// Front pipeline: status decode, log2 by table and interpolation, decibel
// scaling, clamp, and preparation of dividend and divisor.
module slnu_log_conv import slnu_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8,
  parameter int FRAC_BITS      = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               vld_i,
  input  wire logic signed [31:0] sample_i,
  input  wire logic               wend_i,
  input  wire logic               mode_i,
  input  wire logic signed [31:0] lower_i,
  input  wire logic signed [31:0] upper_i,
  output logic                    vld_o,
  output slnu_tag_t               tag_o,
  output logic [31:0]             diff_o,
  output logic [31:0]             den_o
);

  localparam int SH     = 30 - LOG_TABLE_BITS;
  localparam int ROM_N  = 1 << LOG_TABLE_BITS;
  localparam int PROD_W = 29 + SH;
  localparam int RSH    = 2 * LOG_FB - FRAC_BITS;
  localparam int DB_W   = 34;
  localparam logic [32:0] B_VAL = 33'(FRAC_BITS) << LOG_FB;
  localparam logic [63:0] RND   = 64'd1 << (RSH - 1);

  logic [28:0] rom_w [0:ROM_N];
  for (genvar gi = 0; gi <= ROM_N; gi++) begin : g_rom
    localparam logic [28:0] ENTRY = log_rom(gi, LOG_TABLE_BITS);
    assign rom_w[gi] = ENTRY;
  end

  logic [9:1]       vld_r;
  slnu_tag_t        tag_r [1:9];
  logic signed [31:0] s_r [1:8];

  logic [30:0] s1_x_r;
  logic [4:0]  p_r [1:5];
  logic [29:0] s2_frac_r;
  logic [28:0] s3_e0_r, s3_e1_r, s4_e0_r;
  logic [SH-1:0] s3_rest_r;
  logic [PROD_W-1:0] s4_prod_r;
  logic [32:0] s5_mag_r;
  logic        neg_r [5:7];
  logic [47:0] s6_pl_r;
  logic [46:0] s6_ph_r;
  logic [32:0] s7_mag_r;
  logic signed [DB_W-1:0] s8_v_r;
  logic [31:0] s9_diff_r, s9_den_r;

  logic [4:0]  p_nxt;
  slnu_tag_t   tag_nxt;
  logic [30:0] m_w;
  logic [LOG_TABLE_BITS-1:0] idx_w;
  logic [LOG_TABLE_BITS:0]   idx1_w;
  logic [32:0] a_w;
  logic [63:0] sum_w;
  logic signed [DB_W-1:0] db_w, v_w, lo_w, hi_w, vc_w;
  logic signed [DB_W-1:0] diff_w, den_w;

  always_comb begin
    p_nxt = 5'd0;
    for (int i = 1; i < 31; i++) begin
      if (sample_i[i]) begin
        p_nxt = 5'(i);
      end
    end
    tag_nxt.wend = wend_i;
    if (upper_i <= lower_i) begin
      tag_nxt.status = ST_RANGE;
    end else if (mode_i && (sample_i <= 32'sd0)) begin
      tag_nxt.status = ST_NONPOS;
    end else begin
      tag_nxt.status = ST_OK;
    end
  end

  assign m_w    = s1_x_r << (5'd30 - p_r[1]);
  assign idx_w  = s2_frac_r[29:SH];
  assign idx1_w = {1'b0, idx_w} + 1'b1;
  assign a_w    = ({28'd0, p_r[4]} << LOG_FB) + {4'd0, s4_e0_r}
                + 33'(s4_prod_r >> SH);
  assign sum_w  = {16'd0, s6_pl_r} + ({17'd0, s6_ph_r} << 17) + RND;
  assign db_w   = neg_r[7] ? -$signed({1'b0, s7_mag_r}) : $signed({1'b0, s7_mag_r});
  assign v_w    = mode_i ? db_w : DB_W'(s_r[7]);
  assign lo_w   = DB_W'(lower_i);
  assign hi_w   = DB_W'(upper_i);
  assign vc_w   = (s8_v_r < lo_w) ? lo_w : ((s8_v_r > hi_w) ? hi_w : s8_v_r);
  assign diff_w = vc_w - lo_w;
  assign den_w  = hi_w - lo_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[8:1], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[1]  <= tag_nxt;
      s_r[1]    <= sample_i;
      s1_x_r    <= sample_i[30:0];
      p_r[1]    <= p_nxt;
      for (int k = 2; k <= 9; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
      for (int k = 2; k <= 8; k++) begin
        s_r[k] <= s_r[k-1];
      end
      for (int k = 2; k <= 5; k++) begin
        p_r[k] <= p_r[k-1];
      end
      s2_frac_r <= m_w[29:0];
      s3_e0_r   <= rom_w[idx_w];
      s3_e1_r   <= rom_w[idx1_w];
      s3_rest_r <= s2_frac_r[SH-1:0];
      s4_e0_r   <= s3_e0_r;
      s4_prod_r <= PROD_W'(s3_e1_r - s3_e0_r) * PROD_W'(s3_rest_r);
      neg_r[5]  <= (a_w < B_VAL);
      s5_mag_r  <= (a_w < B_VAL) ? (B_VAL - a_w) : (a_w - B_VAL);
      neg_r[6]  <= neg_r[5];
      neg_r[7]  <= neg_r[6];
      s6_pl_r   <= s5_mag_r[16:0] * DB_FACTOR;
      s6_ph_r   <= s5_mag_r[32:17] * DB_FACTOR;
      s7_mag_r  <= 33'(sum_w >> RSH);
      s8_v_r    <= v_w;
      s9_diff_r <= diff_w[31:0];
      s9_den_r  <= den_w[31:0];
    end
  end

  assign vld_o  = vld_r[9];
  assign tag_o  = tag_r[9];
  assign diff_o = s9_diff_r;
  assign den_o  = s9_den_r;

endmodule
`default_nettype wire

// ===== rtl/core/slnu_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per stage: (diff << 16) / den.
// diff never exceeds den, so the quotient fits in LEVEL_W bits.
module slnu_divider import slnu_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         vld_i,
  input  wire slnu_tag_t    tag_i,
  input  wire logic [31:0]  diff_i,
  input  wire logic [31:0]  den_i,
  output logic              vld_o,
  output slnu_tag_t         tag_o,
  output logic [LEVEL_W-1:0] quot_o
);

  logic [LEVEL_W-1:0] vld_r;
  slnu_tag_t          tag_r  [0:LEVEL_W-1];
  logic [32:0]        rem_r  [0:LEVEL_W-1];
  logic [LEVEL_W-1:0] quot_r [0:LEVEL_W-1];
  logic [31:0]        den_r  [0:LEVEL_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LEVEL_W-2:0], vld_i};
    end
  end

  for (genvar k = 0; k < LEVEL_W; k++) begin : g_stage
    logic [32:0]        rin;
    logic [LEVEL_W-1:0] qin;
    logic [31:0]        din;
    slnu_tag_t          tin;
    logic               ge;
    if (k == 0) begin : g_first
      assign rin = {1'b0, diff_i};
      assign qin = '0;
      assign din = den_i;
      assign tin = tag_i;
    end else begin : g_next
      assign rin = {rem_r[k-1][31:0], 1'b0};
      assign qin = quot_r[k-1];
      assign din = den_r[k-1];
      assign tin = tag_r[k-1];
    end
    assign ge = (rin >= {1'b0, din});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rin - {1'b0, din}) : rin;
        quot_r[k] <= {qin[LEVEL_W-2:0], ge};
        den_r[k]  <= din;
        tag_r[k]  <= tin;
      end
    end
  end

  assign vld_o  = vld_r[LEVEL_W-1];
  assign tag_o  = tag_r[LEVEL_W-1];
  assign quot_o = quot_r[LEVEL_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/spectrum_level_normalizer_unit.sv =====
// Spectrum level normalizer: maps one signed Q16.16 sample per word to a
// normalized Q1.16 level for a display colormap.
// Input channel in_*: in_tdata carries the sample, in_tlast marks the last
// sample of a window. Result channel out_*: out_tdata carries level and
// status, out_tlast copies the window flag of the same word.
// In linear mode the sample is clamped to [lower_bound, upper_bound] and
// scaled to (v - lower) / (upper - lower). In decibel mode the sample is first
// turned into 20*log10(sample) through a log2 table with interpolation.
// A nonpositive sample in decibel mode gives status 1, an empty or inverted
// range gives status 2; both give level 0.
// Throughput is one word per cycle while the receiver takes results. There
// are nine stages for the log and clamp path, seventeen divider stages (one
// quotient bit each) and the output register. The whole pipeline advances
// together; when the receiver stalls with a word waiting in the output
// register, in_tready drops and every stage holds. Reset clears all valid
// bits and loads the register defaults: linear mode, lower bound 0, upper
// bound 1.0. Configuration is to be written while idle; this is not enforced.
`default_nettype none
module spectrum_level_normalizer_unit import slnu_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8,
  parameter int FRAC_BITS      = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] sample_value
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [16:0] level, [18:17] status, rest zero
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic               mode_r;
  logic signed [31:0] lower_r;
  logic signed [31:0] upper_r;

  logic               out_vld_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [1:0]         out_status_r;
  logic               out_last_r;

  logic               en;
  logic               lc_vld;
  slnu_tag_t          lc_tag;
  logic [31:0]        lc_diff;
  logic [31:0]        lc_den;
  logic               dv_vld;
  slnu_tag_t          dv_tag;
  logic [LEVEL_W-1:0] dv_quot;

  // The pipeline moves whenever the output register is free or being drained.
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      lower_r <= 32'sd0;
      upper_r <= 32'sd65536;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SCALE_MODE:  mode_r  <= cfg_wdata[0];
        REG_LOWER_BOUND: lower_r <= cfg_wdata;
        REG_UPPER_BOUND: upper_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  slnu_log_conv #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS),
    .FRAC_BITS      (FRAC_BITS)
  ) u_log_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (in_tvalid),
    .sample_i (in_tdata),
    .wend_i   (in_tlast),
    .mode_i   (mode_r),
    .lower_i  (lower_r),
    .upper_i  (upper_r),
    .vld_o    (lc_vld),
    .tag_o    (lc_tag),
    .diff_o   (lc_diff),
    .den_o    (lc_den)
  );

  slnu_divider u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (lc_vld),
    .tag_i  (lc_tag),
    .diff_i (lc_diff),
    .den_i  (lc_den),
    .vld_o  (dv_vld),
    .tag_o  (dv_tag),
    .quot_o (dv_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  // Any nonzero status forces the level to zero.
  always_ff @(posedge clk) begin
    if (en) begin
      out_level_r  <= (dv_tag.status == ST_OK) ? dv_quot : '0;
      out_status_r <= dv_tag.status;
      out_last_r   <= dv_tag.wend;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_status_r, out_level_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_level_r <= 17'd65536))
    else $error("level above full scale");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_status_r != ST_OK)) |-> (out_level_r == '0))
    else $error("nonzero level with error status");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_status_r == ST_OK || out_status_r == ST_NONPOS ||
                    out_status_r == ST_RANGE))
    else $error("undefined status code");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");
`endif

endmodule
`default_nettype wire
